>>> design/lut_filtered_2x_upscale_8bpp_macros.svh
// assertion helpers used by the checker file
`ifndef LUT_FILTERED_2X_UPSCALE_8BPP_MACROS_SVH
`define LUT_FILTERED_2X_UPSCALE_8BPP_MACROS_SVH

// check on every clock edge outside reset
`define LFU_ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lfu check failed");

// check on every clock edge, reset included
`define LFU_ASSERT_ANY(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("lfu check failed");

`endif

>>> design/lfu_pkg.sv
package lfu_pkg;

	// default color index width
	localparam int PIXEL_BITS_DEF = 8;

	// entries between front and back, power of two
	localparam int QUEUE_DEPTH = 4;

	// steps per pixel beat, two table reads per step
	localparam int NUM_STEPS = 4;
	localparam logic [1:0] LAST_STEP = 2'(NUM_STEPS - 1);

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_TABLE = 1'b1
	} kind_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_READ
	} seq_state_t;

	// queue status seen by its neighbors
	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_flags_t;

endpackage

>>> design/lfu_queue.sv
module lfu_queue #(
	parameter int WIDTH = 73,
	parameter int DEPTH = lfu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output lfu_pkg::q_flags_t flags
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign flags.not_empty = (count_q != '0);
	assign flags.not_full  = (count_q != CNT_W'(DEPTH));
	assign head_data       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/lfu_front.sv
module lfu_front #(
	parameter int PIXEL_BITS = lfu_pkg::PIXEL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [31:0]              top_word,
	input  logic [31:0]              below_word,
	input  logic [7:0]               right_pixel,
	input  logic [7:0]               table_first,
	input  logic [7:0]               table_second,
	input  logic [7:0]               table_value,
	input  lfu_pkg::q_flags_t        q_flags,
	output logic                     push,
	output logic [9*PIXEL_BITS:0]    push_data
);

	localparam int PB       = PIXEL_BITS;
	localparam int B_OFS    = 4 * PB;
	localparam int R_OFS    = 8 * PB;
	localparam int KIND_POS = 9 * PB;
	localparam int ENTRY_W  = 9 * PB + 1;

	logic               vld_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [ENTRY_W-1:0] entry_d;
	logic               accept;

	// masked and classified entry
	always_comb begin
		entry_d = '0;
		if (req_type == lfu_pkg::KIND_TABLE) begin
			entry_d[0 +: PB]      = table_first[PB-1:0];
			entry_d[PB +: PB]     = table_second[PB-1:0];
			entry_d[2 * PB +: PB] = table_value[PB-1:0];
			entry_d[KIND_POS]     = lfu_pkg::KIND_TABLE;
		end else begin
			for (int k = 0; k < 4; k++) begin
				entry_d[k * PB +: PB]         = top_word[8 * k +: PB];
				entry_d[B_OFS + k * PB +: PB] = below_word[8 * k +: PB];
			end
			entry_d[R_OFS +: PB] = right_pixel[PB-1:0];
			entry_d[KIND_POS]    = lfu_pkg::KIND_PIXEL;
		end
	end

	assign push      = vld_q && q_flags.not_full;
	assign in_ready  = !vld_q || q_flags.not_full;
	assign accept    = in_valid && in_ready;
	assign push_data = entry_q;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (push) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q <= entry_d;
		end
	end

endmodule

>>> design/lfu_back.sv
module lfu_back #(
	parameter int PIXEL_BITS = lfu_pkg::PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [9*PIXEL_BITS:0] head_data,
	input  lfu_pkg::q_flags_t     q_flags,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           top_first,
	output logic [31:0]           top_second,
	output logic [31:0]           bottom_first,
	output logic [31:0]           bottom_second
);

	localparam int PB       = PIXEL_BITS;
	localparam int AW       = 2 * PB;
	localparam int B_OFS    = 4 * PB;
	localparam int R_OFS    = 8 * PB;
	localparam int KIND_POS = 9 * PB;

	lfu_pkg::seq_state_t state_q, state_d;

	logic [PB-1:0] tbl_q [2**AW];
	logic [PB-1:0] rd0_q, rd1_q;
	logic [PB-1:0] cur_a_q [4];
	logic [PB-1:0] cur_b_q [4];
	logic [PB-1:0] cur_r_q;
	logic [PB-1:0] lk_q [6];
	logic [1:0]    step_q;
	logic          cap_vld_s1;
	logic [1:0]    cap_step_s1;
	logic          out_vld_q;
	logic [31:0]   top_first_q, top_second_q, bottom_first_q, bottom_second_q;

	logic          head_table;
	logic          stall;
	logic          cap_last;
	logic          re, we, load_cur;
	logic [AW-1:0] ra0, ra1;

	assign head_table = (head_data[KIND_POS] == lfu_pkg::KIND_TABLE);
	assign cap_last   = cap_vld_s1 && (cap_step_s1 == lfu_pkg::LAST_STEP);
	// last reads are back but the result register is still held
	assign stall      = cap_last && out_vld_q && !out_ready;

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		load_cur = 1'b0;
		case (state_q)
			lfu_pkg::SEQ_IDLE: begin
				if (!stall && q_flags.not_empty) begin
					pop = 1'b1;
					if (head_table) begin
						we = 1'b1;
					end else begin
						load_cur = 1'b1;
						state_d  = lfu_pkg::SEQ_READ;
					end
				end
			end
			lfu_pkg::SEQ_READ: begin
				if (!stall) begin
					re = 1'b1;
					if (step_q == lfu_pkg::LAST_STEP) begin
						state_d = lfu_pkg::SEQ_IDLE;
					end
				end
			end
			default: begin
				state_d = lfu_pkg::SEQ_IDLE;
			end
		endcase
	end

	// two table addresses per step: horizontal pairs first, then vertical
	always_comb begin
		case (step_q)
			2'd0: begin
				ra0 = {cur_a_q[0], cur_a_q[1]};
				ra1 = {cur_a_q[1], cur_a_q[2]};
			end
			2'd1: begin
				ra0 = {cur_a_q[2], cur_a_q[3]};
				ra1 = {cur_a_q[3], cur_r_q};
			end
			2'd2: begin
				ra0 = {cur_a_q[0], cur_b_q[0]};
				ra1 = {cur_a_q[1], cur_b_q[1]};
			end
			default: begin
				ra0 = {cur_a_q[2], cur_b_q[2]};
				ra1 = {cur_a_q[3], cur_b_q[3]};
			end
		endcase
	end

	// blend table, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			tbl_q[{head_data[0 +: PB], head_data[PB +: PB]}] <= head_data[2 * PB +: PB];
		end
		if (re) begin
			rd0_q <= tbl_q[ra0];
			rd1_q <= tbl_q[ra1];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfu_pkg::SEQ_IDLE;
			step_q      <= '0;
			cap_vld_s1  <= 1'b0;
			cap_step_s1 <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_cur) begin
				step_q <= '0;
			end else if (re) begin
				step_q <= step_q + 1'b1;
			end
			if (!stall) begin
				cap_vld_s1 <= re;
			end
			if (re) begin
				cap_step_s1 <= step_q;
			end
			if (cap_last && !stall) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// current pixel beat
	always_ff @(posedge clk) begin
		if (load_cur) begin
			for (int k = 0; k < 4; k++) begin
				cur_a_q[k] <= head_data[k * PB +: PB];
				cur_b_q[k] <= head_data[B_OFS + k * PB +: PB];
			end
			cur_r_q <= head_data[R_OFS +: PB];
		end
	end

	// collect looked-up colors of the early steps
	always_ff @(posedge clk) begin
		if (cap_vld_s1 && !stall && !cap_last) begin
			lk_q[{cap_step_s1, 1'b0}] <= rd0_q;
			lk_q[{cap_step_s1, 1'b1}] <= rd1_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cap_last && !stall) begin
			top_first_q     <= {8'(lk_q[1]), 8'(cur_a_q[1]), 8'(lk_q[0]), 8'(cur_a_q[0])};
			top_second_q    <= {8'(lk_q[3]), 8'(cur_a_q[3]), 8'(lk_q[2]), 8'(cur_a_q[2])};
			bottom_first_q  <= {8'(lk_q[5]), 8'(lk_q[5]), 8'(lk_q[4]), 8'(lk_q[4])};
			bottom_second_q <= {8'(rd1_q), 8'(rd1_q), 8'(rd0_q), 8'(rd0_q)};
		end
	end

	assign out_valid     = out_vld_q;
	assign top_first     = top_first_q;
	assign top_second    = top_second_q;
	assign bottom_first  = bottom_first_q;
	assign bottom_second = bottom_second_q;

endmodule

>>> design/lut_filtered_2x_upscale_8bpp.sv
// 2x upscaler for indexed pixels, blended through a 2^(2*PIXEL_BITS) entry table.
// Input channel (in_valid/in_ready): req_type 1 writes table entry
// (table_first, table_second) = table_value and gives no result; req_type 0
// carries four pixels (top_word), the four below (below_word) and right_pixel.
// Output channel (out_valid/out_ready): one beat of 2x8 output pixels per
// pixel beat, in input order.
// The back end handles a pixel beat as one load and then four steps of two
// table reads on the two read ports, and a table write as a single write; it
// pops the next item only once the last step of a pixel beat is issued.
// A 4-entry queue between front and back keeps the input open while the
// back end works, and the result register lets the next item start while a
// result waits.
// Reset clears all control state; the table contents stay undefined, so
// every entry must be written before a pixel beat looks it up.
// When the receiver stalls, the back end holds its last lookups, then the
// queue fills and in_ready drops.
module lut_filtered_2x_upscale_8bpp #(
	parameter int PIXEL_BITS = lfu_pkg::PIXEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] top_word,
	input  logic [31:0] below_word,
	input  logic [7:0]  right_pixel,
	input  logic [7:0]  table_first,
	input  logic [7:0]  table_second,
	input  logic [7:0]  table_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] top_first,
	output logic [31:0] top_second,
	output logic [31:0] bottom_first,
	output logic [31:0] bottom_second
);

	localparam int ENTRY_W = 9 * PIXEL_BITS + 1;

	logic               push, pop;
	logic [ENTRY_W-1:0] push_data, head_data;
	lfu_pkg::q_flags_t  q_flags;

	lfu_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.top_word     (top_word),
		.below_word   (below_word),
		.right_pixel  (right_pixel),
		.table_first  (table_first),
		.table_second (table_second),
		.table_value  (table_value),
		.q_flags      (q_flags),
		.push         (push),
		.push_data    (push_data)
	);

	lfu_queue #(.WIDTH(ENTRY_W), .DEPTH(lfu_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.flags     (q_flags)
	);

	lfu_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_data     (head_data),
		.q_flags       (q_flags),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.top_first     (top_first),
		.top_second    (top_second),
		.bottom_first  (bottom_first),
		.bottom_second (bottom_second)
	);

endmodule

>>> design/lfu_checker.sv
`include "lut_filtered_2x_upscale_8bpp_macros.svh"

module lfu_checker #(
	parameter int PIXEL_BITS = lfu_pkg::PIXEL_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] top_first,
	input logic [31:0] top_second,
	input logic [31:0] bottom_first,
	input logic [31:0] bottom_second
);

	localparam logic [7:0]   LANE_HI    = 8'(8'hFF << PIXEL_BITS);
	localparam logic [127:0] PAYLOAD_HI = {16{LANE_HI}};

	logic         out_stall;
	logic [127:0] out_payload;

	assign out_stall   = out_valid && !out_ready;
	assign out_payload = {top_first, top_second, bottom_first, bottom_second};

	// a stalled result beat stays
	`LFU_ASSERT_RST(a_out_hold, clk, arst_n, out_stall |=> out_valid)

	// and keeps its payload
	`LFU_ASSERT_RST(a_out_stable, clk, arst_n, out_stall |=> $stable(out_payload))

	// every output pixel is a color index of PIXEL_BITS bits
	`LFU_ASSERT_RST(a_out_masked, clk, arst_n, out_valid |-> ((out_payload & PAYLOAD_HI) == 128'd0))

	// a reset edge leaves no result beat shown at the next edge
	`LFU_ASSERT_ANY(a_reset_quiet, clk, !arst_n |=> !out_valid)

endmodule

bind lut_filtered_2x_upscale_8bpp lfu_checker #(.PIXEL_BITS(PIXEL_BITS)) u_lfu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.top_first     (top_first),
	.top_second    (top_second),
	.bottom_first  (bottom_first),
	.bottom_second (bottom_second)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	// no accepted beat on either side for this long means the block hung
	localparam int WATCHDOG_LIMIT = 2000;
	// extra wait after the last expected result, to catch strays
	localparam int DRAIN_CYCLES = 24;
	localparam int PALETTE_SIZE = 8;
	localparam int PAL_W = $clog2(PALETTE_SIZE);
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [31:0] top_first;
		logic [31:0] top_second;
		logic [31:0] bottom_first;
		logic [31:0] bottom_second;
	} upscale_out_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = lfu_pkg::KIND_PIXEL;
	logic [31:0] top_word = '0;
	logic [31:0] below_word = '0;
	logic [7:0]  right_pixel = '0;
	logic [7:0]  table_first = '0;
	logic [7:0]  table_second = '0;
	logic [7:0]  table_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] top_first;
	logic [31:0] top_second;
	logic [31:0] bottom_first;
	logic [31:0] bottom_second;

	// shadow copy of the blend table and which entries hold a value
	logic [7:0] blend_mem [0:65535];
	bit         entry_valid [0:65535];

	upscale_out_t pending_results[$];
	logic [7:0]   palette [PALETTE_SIZE];

	bit gaps_on = 1'b1;
	int rx_hold = 0;
	int item_count = 0;
	int pixel_beats = 0;
	int table_writes = 0;
	int results_checked = 0;
	int error_count = 0;

	lut_filtered_2x_upscale_8bpp u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.top_word(top_word),
		.below_word(below_word),
		.right_pixel(right_pixel),
		.table_first(table_first),
		.table_second(table_second),
		.table_value(table_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_first(top_first),
		.top_second(top_second),
		.bottom_first(bottom_first),
		.bottom_second(bottom_second)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one line per failure, printing capped
	task automatic flag_error(string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic logic [7:0] blend_of(logic [7:0] x, logic [7:0] y);
		return blend_mem[{x, y}];
	endfunction

	// expected 2x8 block for one pixel beat from the current table
	function automatic upscale_out_t predict_upscale(logic [31:0] top, logic [31:0] below,
			logic [7:0] right);
		upscale_out_t res;
		logic [7:0]   a [5];
		logic [7:0]   v [4];
		for (int k = 0; k < 4; k++) begin
			a[k] = top[8*k +: 8];
			v[k] = blend_of(a[k], below[8*k +: 8]);
		end
		a[4] = right;
		res.top_first     = {blend_of(a[1], a[2]), a[1], blend_of(a[0], a[1]), a[0]};
		res.top_second    = {blend_of(a[3], a[4]), a[3], blend_of(a[2], a[3]), a[2]};
		res.bottom_first  = {v[1], v[1], v[0], v[0]};
		res.bottom_second = {v[3], v[3], v[2], v[2]};
		return res;
	endfunction

	// drive one input beat, hold it until accepted, then update the shadow state
	task automatic send_beat(lfu_pkg::kind_t kind, logic [31:0] top, logic [31:0] below,
			logic [7:0] right, logic [7:0] first, logic [7:0] second, logic [7:0] value);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		top_word     <= top;
		below_word   <= below;
		right_pixel  <= right;
		table_first  <= first;
		table_second <= second;
		table_value  <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		item_count++;
		if (kind == lfu_pkg::KIND_TABLE) begin
			blend_mem[{first, second}] = value;
			entry_valid[{first, second}] = 1'b1;
			table_writes++;
		end else begin
			pending_results.push_back(predict_upscale(top, below, right));
			pixel_beats++;
		end
	endtask

	// table write with random don't-care pixel fields
	task automatic write_entry(logic [7:0] first, logic [7:0] second, logic [7:0] value);
		send_beat(lfu_pkg::KIND_TABLE, $urandom, $urandom, 8'($urandom_range(0, 255)),
			first, second, value);
	endtask

	task automatic fill_entry(logic [7:0] first, logic [7:0] second);
		if (!entry_valid[{first, second}])
			write_entry(first, second, 8'($urandom_range(0, 255)));
	endtask

	// pixel beat; any table entry it looks up gets written first
	task automatic send_pixel(logic [31:0] top, logic [31:0] below, logic [7:0] right);
		logic [7:0] a [5];
		for (int k = 0; k < 4; k++)
			a[k] = top[8*k +: 8];
		a[4] = right;
		for (int k = 0; k < 4; k++) begin
			fill_entry(a[k], a[k+1]);
			fill_entry(a[k], below[8*k +: 8]);
		end
		send_beat(lfu_pkg::KIND_PIXEL, top, below, right, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic new_palette();
		foreach (palette[i])
			palette[i] = 8'($urandom_range(0, 255));
	endtask

	// mostly palette colors so table entries get reused and rewritten
	function automatic logic [7:0] pick_color();
		if ($urandom_range(0, 19) < 17)
			return palette[PAL_W'($urandom_range(0, PALETTE_SIZE - 1))];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] pick_word();
		return {pick_color(), pick_color(), pick_color(), pick_color()};
	endfunction

	task automatic random_item();
		if ($urandom_range(0, 3) == 0)
			write_entry(pick_color(), pick_color(), 8'($urandom_range(0, 255)));
		else
			send_pixel(pick_word(), pick_word(), pick_color());
	endtask

	// all-zero, all-one and alternating pixels, extreme table indexes and values
	task automatic test_corner_pixels();
		write_entry(8'h00, 8'h00, 8'hFF);
		write_entry(8'hFF, 8'hFF, 8'h00);
		write_entry(8'h00, 8'hFF, 8'h5A);
		write_entry(8'hFF, 8'h00, 8'hA5);
		send_pixel(32'h0000_0000, 32'h0000_0000, 8'h00);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_pixel(32'h00FF_00FF, 32'hFF00_FF00, 8'h00);
		send_pixel(32'hFF00_FF00, 32'h00FF_00FF, 8'hFF);
	endtask

	// flat area: every lookup is the same color paired with itself
	task automatic test_repeated_index();
		write_entry(8'h81, 8'h81, 8'h7E);
		send_pixel(32'h8181_8181, 32'h8181_8181, 8'h81);
	endtask

	// rewrite entries right behind pixel beats that read them
	task automatic test_entry_rewrite();
		write_entry(8'h12, 8'h34, 8'h11);
		write_entry(8'h34, 8'h34, 8'h22);
		send_pixel(32'h3434_3412, 32'h3434_3434, 8'h34);
		write_entry(8'h12, 8'h34, 8'h99);
		send_pixel(32'h3434_3412, 32'h3434_3434, 8'h34);
		write_entry(8'h34, 8'h34, 8'hC3);
		send_pixel(32'h3434_3412, 32'h3434_3434, 8'h34);
	endtask

	// random traffic in blocks, new palette and idling on or off per block
	task automatic test_random_traffic(int n);
		int target;
		int next_block;
		target = item_count + n;
		next_block = item_count;
		while (item_count < target) begin
			if (item_count >= next_block) begin
				new_palette();
				gaps_on = ($urandom_range(0, 3) != 0);
				next_block = item_count + 100;
			end
			random_item();
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_back_to_back(int n);
		int target;
		target = item_count + n;
		gaps_on = 1'b0;
		new_palette();
		while (item_count < target)
			random_item();
	endtask

	// receiver stalls in bursts while idling is on
	always @(posedge clk) begin
		if (!gaps_on) begin
			out_ready <= 1'b1;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			rx_hold <= $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		upscale_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_error("result beat with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("top_first", top_first, want.top_first);
				check_field("top_second", top_second, want.top_second);
				check_field("bottom_first", bottom_first, want.bottom_first);
				check_field("bottom_second", bottom_second, want.bottom_second);
				results_checked++;
			end
		end
	end

	// hang detection
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	// main sequence
	initial begin
		new_palette();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gaps_on = 1'b1;
		test_corner_pixels();
		test_repeated_index();
		test_entry_rewrite();
		test_random_traffic(600);
		test_back_to_back(200);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_results.size()));

		$display("covered %0d pixel beats and %0d table writes, %0d result beats checked",
			pixel_beats, table_writes, results_checked);
		$display("random idling on both sides, full-rate tail, %0d mismatches", error_count);
		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/lfu_pkg.sv
design/lfu_queue.sv
design/lfu_front.sv
design/lfu_back.sv
design/lut_filtered_2x_upscale_8bpp.sv
design/lfu_checker.sv
dv/tb_top.sv
